// File: rtl/hcce_pkg.sv
// Package with shared types, codes and helper functions of the glyph cache engine.
package hcce_pkg;

  localparam int SLOT_BITS_DEF = 11;
  localparam int KEY_W         = 29;
  localparam int BYTES_W       = 20;
  localparam int HANDLE_W      = 32;
  localparam int HEADROOM_W    = 11;
  localparam int CFG_W         = 20;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [BYTES_W-1:0]    BUDGET_RST   = 20'd524288;
  localparam logic [HEADROOM_W-1:0] HEADROOM_RST = 11'd64;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_EVICT  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_HIT         = 4'd0,
    ST_MISS        = 4'd1,
    ST_INSERTED    = 4'd2,
    ST_NEED_SPACE  = 4'd3,
    ST_TOO_LARGE   = 4'd4,
    ST_PRESENT     = 4'd5,
    ST_BAD_SIZE    = 4'd6,
    ST_EVICTED     = 4'd7,
    ST_NOTHING     = 4'd8,
    ST_FLUSHED     = 4'd9
  } status_t;

  typedef enum logic {
    REG_BUDGET   = 1'b0,
    REG_HEADROOM = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HOME, S_PRD, S_PCHK, S_ERD, S_ECHK,
    S_SRD, S_SCHK, S_SHASH, S_SEND, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [20:0]         codepoint;
    logic [7:0]          glyph_size;
    logic [HANDLE_W-1:0] entry_handle;
    logic [BYTES_W-1:0]  entry_bytes;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [20:0]         found_codepoint;
    logic [7:0]          found_size;
    logic [HANDLE_W-1:0] found_handle;
    logic [BYTES_W-1:0]  found_bytes;
  } out_item_t;

  // Key store word: referenced bit above the key.
  typedef struct packed {
    logic             ref_bit;
    logic [KEY_W-1:0] key;
  } kslot_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  nbytes;
  } pslot_t;

  // Invalid codepoints fold to the replacement character before keying.
  function automatic logic [KEY_W-1:0] make_key(input logic [20:0] cp,
                                                input logic [7:0] size);
    logic [20:0] c;
    c = cp;
    if (cp == 21'd0 || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
      c = 21'hFFFD;
    end
    return {c, size};
  endfunction

endpackage

// File: rtl/hcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hcce_hash.sv
// Registered Fibonacci hash: home slot from the top bits of key times the golden constant.
module hcce_hash #(
  parameter int SLOT_BITS = hcce_pkg::SLOT_BITS_DEF
) (
  input  logic                       clk,
  input  logic [hcce_pkg::KEY_W-1:0] key,
  output logic [SLOT_BITS-1:0]       home
);
  import hcce_pkg::*;

  logic [31:0] prod;

  assign prod = {{(32-KEY_W){1'b0}}, key} * HASH_MULT;

  always_ff @(posedge clk) begin
    home <= prod[31 -: SLOT_BITS];
  end
endmodule

// File: rtl/hashed_cache_clock_eviction.sv
// Top level of the glyph cache engine: control sequencer, key store and payload store.
// Lookup and insert probe onward from the home slot; evict advances the clock hand and then
// backward-shifts the chain behind an evicted entry; flush reruns the clearing pass; a bad size skips probing.
// Throughput: one item at a time, set by the single read port of the key store.
// Reset: synchronous; after reset a clearing pass empties the key store while input stays
// stalled; configuration writes are taken throughout.
module hashed_cache_clock_eviction #(
  parameter int SLOT_BITS = hcce_pkg::SLOT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  hcce_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hcce_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [hcce_pkg::CFG_W-1:0] cfg_data
);
  import hcce_pkg::*;

  localparam int CAP  = 1 << SLOT_BITS;
  localparam int LW   = ((SLOT_BITS + 1) > HEADROOM_W ? SLOT_BITS + 1 : HEADROOM_W) + 1;
  localparam int KS_W = KEY_W + 1;
  localparam int PS_W = HANDLE_W + BYTES_W;

  state_t state, state_next;

  logic [1:0]              op_r;
  logic [KEY_W-1:0]        key_r;
  logic [HANDLE_W-1:0]     handle_r;
  logic [BYTES_W-1:0]      bytes_r;
  logic [SLOT_BITS-1:0]    idx, hole, hand;
  logic [SLOT_BITS+1:0]    cnt;
  logic [SLOT_BITS:0]      live;
  logic [BYTES_W-1:0]      used, budget;
  logic [HEADROOM_W-1:0]   headroom;
  logic                    flush_pending;
  out_item_t               res;
  kslot_t                  sh_k;
  pslot_t                  sh_p;

  logic                    kwe, pwe;
  logic [SLOT_BITS-1:0]    kwaddr, pwaddr, raddr;
  kslot_t                  kwdata, krd;
  pslot_t                  pwdata, prd;
  logic [KEY_W-1:0]        hash_key, in_key;
  logic [SLOT_BITS-1:0]    home;
  logic [LW-1:0]           live_sum;
  logic [BYTES_W:0]        byte_sum;
  logic                    no_space, shift_ok;

  // Result item that carries only a status, with every found field zero.
  function automatic out_item_t status_only(input status_t st);
    out_item_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  hcce_ram #(.WIDTH(KS_W), .DEPTH(CAP)) u_kram (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(raddr), .rdata(krd)
  );

  hcce_ram #(.WIDTH(PS_W), .DEPTH(CAP)) u_pram (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata), .raddr(raddr), .rdata(prd)
  );

  hcce_hash #(.SLOT_BITS(SLOT_BITS)) u_hash (
    .clk(clk), .key(hash_key), .home(home)
  );

  assign in_key   = make_key(in_data.codepoint, in_data.glyph_size);
  assign hash_key = (state == S_IDLE) ? in_key : krd.key;
  assign in_stall = (state != S_IDLE);
  assign live_sum = LW'(live) + LW'(headroom);
  assign byte_sum = {1'b0, used} + {1'b0, bytes_r};
  assign no_space = (live_sum >= LW'(CAP)) || (byte_sum > {1'b0, budget});
  // Move the entry back when its home does not lie between the hole and itself.
  assign shift_ok = ((idx - home) >= (idx - hole));

  always_comb begin
    state_next = state;
    kwe    = 1'b0;
    pwe    = 1'b0;
    kwaddr = idx;
    pwaddr = idx;
    kwdata = '0;
    pwdata = sh_p;
    raddr  = idx;
    case (state)
      S_CLEAR: begin
        kwe    = 1'b1;
        kwaddr = cnt[SLOT_BITS-1:0];
        if (cnt[SLOT_BITS-1:0] == SLOT_BITS'(CAP - 1)) begin
          state_next = flush_pending ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_data.op))
            OP_FLUSH: state_next = S_CLEAR;
            OP_EVICT: state_next = S_ERD;
            default:  state_next = (in_data.glyph_size == 8'd0) ? S_DONE : S_HOME;
          endcase
        end
      end
      S_HOME: state_next = S_PRD;
      S_PRD:  state_next = S_PCHK;
      S_PCHK: begin
        state_next = S_DONE;
        if (krd.key == key_r) begin
          if (op_r == OP_LOOKUP) begin
            kwe    = 1'b1;
            kwdata = '{ref_bit: 1'b1, key: krd.key};
          end
        end else if (krd.key == '0 || cnt[SLOT_BITS-1:0] == SLOT_BITS'(CAP - 1)) begin
          if (op_r == OP_INSERT && bytes_r <= budget && !no_space && krd.key == '0) begin
            kwe    = 1'b1;
            kwdata = '{ref_bit: 1'b0, key: key_r};
            pwe    = 1'b1;
            pwdata = '{handle: handle_r, nbytes: bytes_r};
          end
        end else begin
          state_next = S_PRD;
        end
      end
      S_ERD: begin
        raddr      = hand;
        state_next = S_ECHK;
      end
      S_ECHK: begin
        kwaddr = idx;
        if (krd.key == '0 || krd.ref_bit) begin
          if (krd.key != '0) begin
            kwe    = 1'b1;
            kwdata = '{ref_bit: 1'b0, key: krd.key};
          end
          state_next = (cnt == (SLOT_BITS+2)'(2 * CAP - 1)) ? S_DONE : S_ERD;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        raddr      = idx + 1'b1;
        state_next = (cnt[SLOT_BITS:0] == (SLOT_BITS+1)'(CAP - 1)) ? S_SEND : S_SCHK;
      end
      S_SCHK: begin
        state_next = (krd.key == '0) ? S_SEND : S_SHASH;
      end
      S_SHASH: begin
        if (shift_ok) begin
          kwe    = 1'b1;
          kwaddr = hole;
          kwdata = sh_k;
          pwe    = 1'b1;
          pwaddr = hole;
          pwdata = sh_p;
        end
        state_next = S_SRD;
      end
      S_SEND: begin
        kwe    = 1'b1;
        kwaddr = hole;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget   <= BUDGET_RST;
      headroom <= HEADROOM_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BUDGET:   budget   <= cfg_data;
        REG_HEADROOM: headroom <= cfg_data[HEADROOM_W-1:0];
        default:      budget   <= budget;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath and bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      live          <= '0;
      used          <= '0;
      hand          <= '0;
      flush_pending <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[SLOT_BITS-1:0] == SLOT_BITS'(CAP - 1)) begin
            flush_pending <= 1'b0;
            res           <= status_only(ST_FLUSHED);
          end
        end
        S_IDLE: begin
          op_r     <= in_data.op;
          key_r    <= in_key;
          handle_r <= in_data.entry_handle;
          bytes_r  <= in_data.entry_bytes;
          cnt      <= '0;
          res      <= status_only(ST_BAD_SIZE);
          if (in_valid && in_data.op == OP_FLUSH) begin
            flush_pending <= 1'b1;
            live          <= '0;
            used          <= '0;
            hand          <= '0;
          end
        end
        S_HOME: begin
          idx <= home;
          cnt <= '0;
        end
        S_PCHK: begin
          if (krd.key == key_r) begin
            res <= '{status: (op_r == OP_LOOKUP) ? ST_HIT : ST_PRESENT,
                     found_codepoint: krd.key[KEY_W-1:8], found_size: krd.key[7:0],
                     found_handle: prd.handle, found_bytes: prd.nbytes};
          end else if (krd.key == '0 || cnt[SLOT_BITS-1:0] == SLOT_BITS'(CAP - 1)) begin
            if (op_r == OP_LOOKUP) begin
              res <= status_only(ST_MISS);
            end else if (bytes_r > budget) begin
              res <= status_only(ST_TOO_LARGE);
            end else if (no_space || krd.key != '0) begin
              res <= status_only(ST_NEED_SPACE);
            end else begin
              res  <= '{status: ST_INSERTED, found_codepoint: key_r[KEY_W-1:8],
                        found_size: key_r[7:0], found_handle: handle_r,
                        found_bytes: bytes_r};
              live <= live + 1'b1;
              used <= byte_sum[BYTES_W-1:0];
            end
          end else begin
            idx <= idx + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        S_ERD: begin
          idx <= hand;
        end
        S_ECHK: begin
          hand <= hand + 1'b1;
          if (krd.key == '0 || krd.ref_bit) begin
            cnt <= cnt + 1'b1;
            res <= status_only(ST_NOTHING);
          end else begin
            res  <= '{status: ST_EVICTED, found_codepoint: krd.key[KEY_W-1:8],
                      found_size: krd.key[7:0], found_handle: prd.handle,
                      found_bytes: prd.nbytes};
            used <= used - prd.nbytes;
            live <= live - 1'b1;
            hole <= idx;
            cnt  <= '0;
          end
        end
        S_SRD: begin
          idx <= idx + 1'b1;
        end
        S_SCHK: begin
          sh_k <= krd;
          sh_p <= prd;
        end
        S_SHASH: begin
          if (shift_ok) begin
            hole <= idx;
          end
          cnt <= cnt + 1'b1;
        end
        default: cnt <= cnt;
      endcase
    end
  end

  property p_live_bound;
    @(posedge clk) disable iff (rst) live <= (SLOT_BITS+1)'(CAP);
  endproperty
  a_live_bound: assert property (p_live_bound) else $error("live count above capacity");

  property p_flush_clears;
    @(posedge clk) disable iff (rst)
      (in_valid && !in_stall && in_data.op == OP_FLUSH) |=> (state == S_CLEAR);
  endproperty
  a_flush_clears: assert property (p_flush_clears) else $error("flush did not start clear");

  property p_idle_no_write;
    @(posedge clk) disable iff (rst) (state == S_IDLE) |-> (!kwe && !pwe);
  endproperty
  a_idle_no_write: assert property (p_idle_no_write) else $error("store written while idle");

  property p_done_delivers;
    @(posedge clk) disable iff (rst)
      (state == S_DONE && !(out_valid && out_stall)) |=> out_valid;
  endproperty
  a_done_delivers: assert property (p_done_delivers) else $error("result not loaded");
endmodule

// File: tb/hcce_checker.sv
// Checker for the glyph cache engine: mirrors the table, predicts each answer and compares.
`timescale 1ns / 100ps

module hcce_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  hcce_pkg::in_item_t        in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  hcce_pkg::out_item_t       out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [hcce_pkg::CFG_W-1:0] cfg_data,
  output int                        errors,
  output int                        waiting,
  output int                        checked
);
  import hcce_pkg::*;

  localparam int CAP  = 1 << SLOT_BITS_DEF;
  localparam int MASK = CAP - 1;

  logic [KEY_W-1:0]    tbl_key [CAP];
  bit                  tbl_ref [CAP];
  logic [HANDLE_W-1:0] tbl_handle [CAP];
  logic [BYTES_W-1:0]  tbl_bytes [CAP];
  int                  live_entries;
  logic [BYTES_W-1:0]  bytes_held;
  int                  hand;
  logic [BYTES_W-1:0]  budget;
  logic [HEADROOM_W-1:0] headroom;

  out_item_t answers_due[$];

  function automatic int home_slot(logic [KEY_W-1:0] key);
    logic [31:0] prod;
    prod = {3'b000, key} * 32'd2654435761;
    return int'(prod[31:32-SLOT_BITS_DEF]);
  endfunction

  function automatic void wipe_slot(int i);
    tbl_key[i] = '0;
    tbl_ref[i] = 1'b0;
    tbl_handle[i] = '0;
    tbl_bytes[i] = '0;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < CAP; i++) wipe_slot(i);
    live_entries = 0;
    bytes_held = '0;
    hand = 0;
  endfunction

  function automatic out_item_t describe_slot(status_t st, int i);
    out_item_t r;
    r.status = st;
    r.found_codepoint = tbl_key[i][28:8];
    r.found_size = tbl_key[i][7:0];
    r.found_handle = tbl_handle[i];
    r.found_bytes = tbl_bytes[i];
    return r;
  endfunction

  // Backward-shift removal keeps probe chains unbroken without tombstones.
  function automatic void drop_slot(int idx);
    int hole;
    int h;
    bit stop;
    bytes_held = bytes_held - tbl_bytes[idx];
    wipe_slot(idx);
    live_entries--;
    hole = idx;
    stop = 0;
    for (int p = 0; p + 1 < CAP && !stop; p++) begin
      idx = (idx + 1) & MASK;
      if (tbl_key[idx] == '0) begin
        stop = 1;
      end else begin
        h = home_slot(tbl_key[idx]);
        if (((idx - h) & MASK) >= ((idx - hole) & MASK)) begin
          tbl_key[hole] = tbl_key[idx];
          tbl_ref[hole] = tbl_ref[idx];
          tbl_handle[hole] = tbl_handle[idx];
          tbl_bytes[hole] = tbl_bytes[idx];
          wipe_slot(idx);
          hole = idx;
        end
      end
    end
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] key);
    int idx;
    int res;
    bit stop;
    idx = home_slot(key);
    res = -1;
    stop = 0;
    for (int p = 0; p < CAP && !stop; p++) begin
      if (tbl_key[idx] == key) begin
        res = idx;
        stop = 1;
      end else if (tbl_key[idx] == '0) begin
        stop = 1;
      end
      idx = (idx + 1) & MASK;
    end
    return res;
  endfunction

  function automatic out_item_t cache_answer(in_item_t it);
    out_item_t r;
    logic [20:0] cp;
    logic [KEY_W-1:0] key;
    int idx;
    bit done;
    r = '0;
    done = 0;
    case (op_t'(it.op))
      OP_FLUSH: begin
        wipe_table();
        r.status = ST_FLUSHED;
      end
      OP_EVICT: begin
        r.status = ST_NOTHING;
        // Second chance: a referenced entry loses its bit and is passed over once.
        for (int p = 0; p < 2 * CAP && !done; p++) begin
          idx = hand;
          hand = (idx + 1) & MASK;
          if (tbl_key[idx] != '0) begin
            if (tbl_ref[idx]) begin
              tbl_ref[idx] = 1'b0;
            end else begin
              r = describe_slot(ST_EVICTED, idx);
              drop_slot(idx);
              done = 1;
            end
          end
        end
      end
      default: begin
        if (it.glyph_size == 8'd0) begin
          r.status = ST_BAD_SIZE;
        end else begin
          cp = it.codepoint;
          if (cp == 21'd0 || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
            cp = 21'hFFFD;
          end
          key = {cp, it.glyph_size};
          idx = find_slot(key);
          if (op_t'(it.op) == OP_LOOKUP) begin
            if (idx >= 0) begin
              tbl_ref[idx] = 1'b1;
              r = describe_slot(ST_HIT, idx);
            end else begin
              r.status = ST_MISS;
            end
          end else if (idx >= 0) begin
            r = describe_slot(ST_PRESENT, idx);
          end else if (it.entry_bytes > budget) begin
            r.status = ST_TOO_LARGE;
          end else if (live_entries + int'(headroom) >= CAP ||
                       int'(bytes_held) + int'(it.entry_bytes) > int'(budget)) begin
            r.status = ST_NEED_SPACE;
          end else begin
            idx = home_slot(key);
            while (tbl_key[idx] != '0) idx = (idx + 1) & MASK;
            tbl_key[idx] = key;
            tbl_ref[idx] = 1'b0;
            tbl_handle[idx] = it.entry_handle;
            tbl_bytes[idx] = it.entry_bytes;
            live_entries++;
            bytes_held = bytes_held + it.entry_bytes;
            r = describe_slot(ST_INSERTED, idx);
          end
        end
      end
    endcase
    return r;
  endfunction

  assign waiting = answers_due.size();

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      wipe_table();
      budget = BUDGET_RST;
      headroom = HEADROOM_RST;
      answers_due.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BUDGET) budget = cfg_data[BYTES_W-1:0];
        else headroom = cfg_data[HEADROOM_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          exp_item = answers_due.pop_front();
          checked <= checked + 1;
          if (exp_item !== out_data) begin
            errors <= errors + 1;
            if (exp_item.status !== out_data.status)
              $display("%0t: status expected %0d actual %0d", $time,
                       exp_item.status, out_data.status);
            if (exp_item.found_codepoint !== out_data.found_codepoint)
              $display("%0t: codepoint expected %h actual %h", $time,
                       exp_item.found_codepoint, out_data.found_codepoint);
            if (exp_item.found_size !== out_data.found_size)
              $display("%0t: size expected %0d actual %0d", $time,
                       exp_item.found_size, out_data.found_size);
            if (exp_item.found_handle !== out_data.found_handle)
              $display("%0t: handle expected %h actual %h", $time,
                       exp_item.found_handle, out_data.found_handle);
            if (exp_item.found_bytes !== out_data.found_bytes)
              $display("%0t: bytes expected %0d actual %0d", $time,
                       exp_item.found_bytes, out_data.found_bytes);
          end
        end
      end
      if (in_valid && !in_stall) answers_due.push_back(cache_answer(in_data));
    end
  end

endmodule

// File: tb/tb_hashed_cache_clock_eviction.sv
// Testbench top for the glyph cache engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_hashed_cache_clock_eviction;
  import hcce_pkg::*;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors;
  int               waiting;
  int               checked;

  int               items_sent;
  logic [BYTES_W-1:0] cur_budget;
  logic [20:0]      key_cp [48];
  logic [7:0]       key_size [48];

  hashed_cache_clock_eviction uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hcce_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .waiting(waiting), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("hashed_cache_clock_eviction: mismatch");
    $finish;
  end

  // The result side stalls in bursts, with calm stretches in between.
  always @(posedge clk) begin
    int stall_left;
    int cyc;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      cyc = 0;
    end else begin
      cyc++;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ((cyc / 400) % 3 == 2 || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic send(op_t op, logic [20:0] cp, logic [7:0] size,
                      logic [31:0] handle, logic [19:0] nbytes);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{op: op, codepoint: cp, glyph_size: size,
                 entry_handle: handle, entry_bytes: nbytes};
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = $urandom_range(0, 19);
    gap = (gap < 13) ? 0 : (gap < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BUDGET) cur_budget = val;
  endtask

  task automatic random_phase(int count);
    int k;
    int pick;
    logic [20:0] cp;
    logic [7:0] size;
    logic [19:0] nb;
    op_t op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 38) ? OP_LOOKUP : (pick < 80) ? OP_INSERT : (pick < 98) ? OP_EVICT : OP_FLUSH;
      k = $urandom_range(0, 47);
      cp = key_cp[k];
      size = key_size[k];
      if ($urandom_range(0, 9) == 0) begin
        cp = 21'($urandom);
        size = 8'($urandom);
      end
      nb = (cur_budget < 16) ? cur_budget : 20'($urandom_range(0, cur_budget / 8));
      if ($urandom_range(0, 11) == 0) nb = 20'($urandom);
      send(op, cp, size, $urandom, nb);
    end
  endtask

  initial begin
    logic [31:0] prod;
    int base_home;
    int found;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_BUDGET;
    cfg_data = '0;
    items_sent = 0;
    cur_budget = BUDGET_RST;

    // Eight keys share one home slot so that probing and backward shift get exercised.
    found = 0;
    for (int c = 21'h1000; found < 8; c++) begin
      prod = {3'b000, c[20:0], 8'd1} * 32'd2654435761;
      if (found == 0) base_home = int'(prod[31:21]);
      if (int'(prod[31:21]) == base_home) begin
        key_cp[found] = c[20:0];
        key_size[found] = 8'd1;
        found++;
      end
    end
    for (int i = 8; i < 48; i++) begin
      key_cp[i] = 21'($urandom_range(1, 21'h10FFFF));
      key_size[i] = 8'($urandom_range(1, 3));
    end
    key_cp[46] = 21'hD800;
    key_cp[47] = 21'h1FFFFF;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(OP_LOOKUP, key_cp[0], 8'd1, 32'h0, 20'h0);
    send(OP_INSERT, key_cp[0], 8'd0, 32'h1, 20'h1);
    send(OP_LOOKUP, key_cp[0], 8'd0, 32'h0, 20'h0);
    send(OP_INSERT, 21'd0, 8'd255, 32'hFFFFFFFF, 20'd100);
    send(OP_LOOKUP, 21'hD800, 8'd255, 32'h0, 20'h0);
    send(OP_LOOKUP, 21'h110000, 8'd255, 32'h0, 20'h0);
    send(OP_INSERT, 21'h1FFFFF, 8'd255, 32'h5, 20'hFFFFF);
    send(OP_INSERT, 21'h10FFFF, 8'd128, 32'hA5A5A5A5, 20'd524288);
    send(OP_INSERT, 21'hFFFD, 8'd255, 32'h7, 20'd7);
    for (int i = 0; i < 4; i++) send(OP_INSERT, key_cp[i], 8'd1, $urandom, 20'(10 + i));
    send(OP_LOOKUP, key_cp[1], 8'd1, 32'h0, 20'h0);
    for (int i = 0; i < 6; i++) send(OP_EVICT, 21'd0, 8'd0, 32'h0, 20'h0);
    send(OP_LOOKUP, key_cp[3], 8'd1, 32'h0, 20'h0);
    send(OP_EVICT, 21'h1FFFFF, 8'd255, 32'hFFFFFFFF, 20'hFFFFF);
    send(OP_FLUSH, 21'h1FFFFF, 8'd255, 32'hFFFFFFFF, 20'hFFFFF);
    send(OP_EVICT, 21'd0, 8'd0, 32'h0, 20'h0);
    settle();

    random_phase(120);
    settle();
    write_reg(REG_BUDGET, 20'hFFFFF);
    write_reg(REG_HEADROOM, 20'd0);
    random_phase(110);
    settle();
    // Lower the budget under what is already held: inserts answer need-space until evictions make room.
    write_reg(REG_BUDGET, 20'd3000);
    write_reg(REG_HEADROOM, 20'd2040);
    random_phase(100);
    settle();
    write_reg(REG_BUDGET, 20'd0);
    write_reg(REG_HEADROOM, 20'd2047);
    random_phase(40);
    settle();
    write_reg(REG_BUDGET, 20'd60000);
    write_reg(REG_HEADROOM, 20'd1024);
    random_phase(110);
    settle();
    write_reg(REG_BUDGET, 20'd400);
    write_reg(REG_HEADROOM, 20'd2044);
    random_phase(80);
    settle();
    write_reg(REG_BUDGET, 20'd524288);
    write_reg(REG_HEADROOM, 20'd1);
    random_phase(60);
    settle();

    $display("Sent %0d items over seven register settings; %0d answers compared, %0d wrong.",
             items_sent, checked, errors);
    if (errors == 0) begin
      $display("hashed_cache_clock_eviction: match");
    end else begin
      $display("hashed_cache_clock_eviction: mismatch");
    end
    $finish;
  end

endmodule

// File: hashed_cache_clock_eviction.f
rtl/hcce_pkg.sv
rtl/hcce_ram.sv
rtl/hcce_hash.sv
rtl/hashed_cache_clock_eviction.sv
tb/hcce_checker.sv
tb/tb_hashed_cache_clock_eviction.sv
